// File: rtl/kpd_pkg.sv
// Shared types and constants for the Kuramoto phase-derivative block.
// Holds input function codes, register indexes, controller states and the
// quarter-wave sine polynomial used to build the sine table.
`default_nettype none

package kpd_pkg;

	// Input beat function codes
	localparam logic [1:0] FUNC_WR_WEIGHT = 2'd0;
	localparam logic [1:0] FUNC_WR_FREQ   = 2'd1;
	localparam logic [1:0] FUNC_WR_PHASE  = 2'd2;
	localparam logic [1:0] FUNC_EVAL      = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_COUPLING_GAIN = 3'd0;
	localparam logic [2:0] REG_FORCING_GAIN  = 3'd1;
	localparam logic [2:0] REG_FREQ_VENTRAL  = 3'd2;
	localparam logic [2:0] REG_FREQ_DORSAL   = 3'd3;
	localparam logic [2:0] REG_DAYLIGHT      = 3'd4;
	localparam logic [2:0] REG_VENTRAL_COUNT = 3'd5;

	// Stored weight codes
	localparam logic [1:0] W_ZERO = 2'b00;
	localparam logic [1:0] W_POS  = 2'b01;
	localparam logic [1:0] W_NEG  = 2'b11;

	// Light profile breakpoints in turns (3 h, 9 h) and the wrap offset (+15 h)
	localparam logic [31:0] PH_DAWN  = 32'h2000_0000;
	localparam logic [31:0] PH_DUSK  = 32'h6000_0000;
	localparam logic [32:0] PH_SHIFT = 33'h0_A000_0000;

	// Divide by three: 32-bit reciprocal (product >> 33) and floor(2^32 / 3)
	localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
	localparam logic [31:0] THIRD_2_32 = 32'd1431655765;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_WUPD,
		ST_ESELF,
		ST_ELOOP,
		ST_EDRAIN,
		ST_EDIV,
		ST_EMUL,
		ST_ESUM,
		ST_EOUT
	} kpd_state_t;

	// Quarter-wave sine, u in Q30 over [0, 1], result Q30 clamped to 1.0
	function automatic logic [30:0] quarter_sine(input longint unsigned u);
		longint unsigned u2;
		longint unsigned p;
		u2 = (u * u) >> 30;
		p = 64'd61;
		p = 64'd3864 - ((p * u2) >> 30);
		p = 64'd172272 - ((p * u2) >> 30);
		p = 64'd5026995 - ((p * u2) >> 30);
		p = 64'd85569306 - ((p * u2) >> 30);
		p = 64'd693598668 - ((p * u2) >> 30);
		p = 64'd1686629713 - ((p * u2) >> 30);
		p = (p * u) >> 30;
		if (p > 64'd1073741824) begin
			p = 64'd1073741824;
		end
		return p[30:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/kpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module kpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                   wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/kuramoto_phase_derivative.sv
// Evaluation: one weight/phase memory read per source node, then a one-bit-per-cycle
// divider; the next beat can be taken once the result enters the output register.
// Writes: weight is a read-modify-write of weight and in-degree; others write in FETCH.
// One beat in flight; a finished result waits in the output register.
// Reset: asynchronous, active low; then a clearing pass over all NODES*NODES weight
// addresses zeroes all stores, during which input is stalled (configuration still taken).
`default_nettype none

module kuramoto_phase_derivative
	import kpd_pkg::*;
#(
	parameter int NODES = 128,
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [6:0]         node,
	input  wire logic [6:0]         source,
	input  wire logic signed [1:0]  weight,
	input  wire logic [15:0]        freq_factor,
	input  wire logic [31:0]        phase_turns,
	input  wire logic [31:0]        time_turns,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [6:0]              node_out,
	output logic signed [31:0]      derivative,
	output logic                    light_on
);

	localparam int NW      = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int WDEPTH  = NODES * NODES;
	localparam int AW      = $clog2(WDEPTH);
	localparam int DEGW    = $clog2(NODES + 1);
	localparam int SUMW    = 32 + NW + 1;
	localparam int DCW     = $clog2(SUMW + 1);
	localparam int STB     = SINE_TABLE_BITS;
	localparam int QW      = STB - 2;
	localparam int QUARTER = 1 << QW;
	localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

	// Quarter-wave sine table, Q30, built at elaboration
	typedef logic [30:0] qtab_t [QUARTER+1];

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int m = 0; m <= QUARTER; m++) begin
			t[m] = quarter_sine(64'(m) << (30 - QW));
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// Full-turn sine lookup through quarter-wave symmetry, Q2.30
	function automatic logic signed [31:0] sine_lookup(input logic [31:0] turns);
		logic [STB-1:0] k;
		logic [QW:0]    m;
		logic [31:0]    v;
		k = turns[31 -: STB];
		m = k[STB-2] ? ((QW+1)'(QUARTER) - {1'b0, k[QW-1:0]}) : {1'b0, k[QW-1:0]};
		v = {1'b0, QTAB[m]};
		return k[STB-1] ? -signed'(v) : signed'(v);
	endfunction

	function automatic logic [AW-1:0] wt_addr(input logic [NW-1:0] src, input logic [NW-1:0] dst);
		return AW'(32'(src) * NODES + 32'(dst));
	endfunction

	kpd_state_t state_q, state_d;

	// configuration registers
	logic signed [31:0] coupling_gain_q, forcing_gain_q, freq_ventral_q, freq_dorsal_q;
	logic [15:0]        daylight_q;
	logic [7:0]         ventral_count_q;

	// captured input beat
	logic [1:0]  func_q;
	logic [6:0]  node_q, source_q;
	logic [1:0]  wenc_q;
	logic [15:0] ffac_q;
	logic [31:0] phase_q, time_q;

	// memory ports
	logic            wt_we, dg_we, fq_we, ph_we;
	logic [AW-1:0]   wt_waddr, wt_raddr;
	logic [NW-1:0]   nd_waddr, nd_raddr, ph_raddr;
	logic [1:0]      wt_wdata, wt_rdata;
	logic [DEGW-1:0] dg_wdata, dg_rdata;
	logic [15:0]     fq_wdata, fq_rdata;
	logic [31:0]     ph_wdata, ph_rdata;

	// control
	logic [AW-1:0]  clr_q;
	logic [NW-1:0]  j_q;
	logic           rd_v_s1, v_s2;
	logic [1:0]     w_s2;
	logic signed [31:0] sin_s2;
	logic signed [SUMW-1:0] sum_q;
	logic [DEGW-1:0] deg_q;
	logic [15:0]     freq_q;
	logic [31:0]     self_q;
	logic [DCW-1:0]  div_cnt_q;
	logic [DEGW:0]   rem_q;
	logic [SUMW-1:0] quo_q;
	logic            neg_q;
	logic [32:0]     x3_q;
	logic [63:0]     m3_q;
	logic [31:0]     q3_q;
	logic            dead_q;
	logic signed [63:0] prod_k_q, prod_w_q, prod_f_q;
	logic signed [31:0] total_q;
	logic            out_valid_q;
	logic [6:0]      node_out_q;
	logic signed [31:0] deriv_q;
	logic            light_out_q;

	logic accept, node_ok, src_ok, is_last_j, drain_done, div_done, out_free;
	logic ventral, light, force_en;
	logic [NW-1:0] nidx, sidx;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign nidx       = NW'(node_q);
	assign sidx       = NW'(source_q);
	assign node_ok    = 32'(node_q) < NODES;
	assign src_ok     = 32'(source_q) < NODES;
	assign is_last_j  = (j_q == NW'(NODES - 1));
	assign drain_done = !rd_v_s1 && !v_s2;
	assign div_done   = (div_cnt_q == '0);
	assign out_free   = !out_valid_q || !out_stall;
	assign ventral    = 32'(node_q) < 32'(ventral_count_q);
	assign light      = time_q < {daylight_q, 16'h0000};
	assign force_en   = ventral && light;

	assign out_valid  = out_valid_q;
	assign node_out   = node_out_q;
	assign derivative = deriv_q;
	assign light_on   = light_out_q;

	// Memories
	kpd_ram #(.WIDTH(2), .DEPTH(WDEPTH)) u_wt_ram (
		.clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
		.raddr(wt_raddr), .rdata(wt_rdata)
	);
	kpd_ram #(.WIDTH(DEGW), .DEPTH(NODES)) u_dg_ram (
		.clk(clk), .we(dg_we), .waddr(nd_waddr), .wdata(dg_wdata),
		.raddr(nd_raddr), .rdata(dg_rdata)
	);
	kpd_ram #(.WIDTH(16), .DEPTH(NODES)) u_fq_ram (
		.clk(clk), .we(fq_we), .waddr(nd_waddr), .wdata(fq_wdata),
		.raddr(nd_raddr), .rdata(fq_rdata)
	);
	kpd_ram #(.WIDTH(32), .DEPTH(NODES)) u_ph_ram (
		.clk(clk), .we(ph_we), .waddr(nd_waddr), .wdata(ph_wdata),
		.raddr(ph_raddr), .rdata(ph_rdata)
	);

	// Memory address and write control
	always_comb begin
		wt_we    = 1'b0;
		dg_we    = 1'b0;
		fq_we    = 1'b0;
		ph_we    = 1'b0;
		wt_waddr = wt_addr(sidx, nidx);
		nd_waddr = nidx;
		wt_wdata = wenc_q;
		dg_wdata = dg_rdata;
		fq_wdata = ffac_q;
		ph_wdata = phase_q;
		wt_raddr = wt_addr(sidx, nidx);
		nd_raddr = nidx;
		ph_raddr = nidx;
		case (state_q)
			ST_CLEAR: begin
				wt_we    = 1'b1;
				wt_waddr = clr_q;
				wt_wdata = W_ZERO;
				nd_waddr = NW'(clr_q);
				dg_we    = (32'(clr_q) < NODES);
				fq_we    = dg_we;
				ph_we    = dg_we;
				dg_wdata = '0;
				fq_wdata = '0;
				ph_wdata = '0;
			end
			ST_FETCH: begin
				fq_we = node_ok && (func_q == FUNC_WR_FREQ);
				ph_we = node_ok && (func_q == FUNC_WR_PHASE);
			end
			ST_WUPD: begin
				wt_we = 1'b1;
				dg_we = 1'b1;
				if (wt_rdata != W_ZERO && wenc_q == W_ZERO) begin
					dg_wdata = dg_rdata - DEGW'(1);
				end else if (wt_rdata == W_ZERO && wenc_q != W_ZERO) begin
					dg_wdata = dg_rdata + DEGW'(1);
				end else begin
					dg_wdata = dg_rdata;
				end
			end
			ST_ESELF: begin
				wt_raddr = wt_addr('0, nidx);
				ph_raddr = '0;
			end
			ST_ELOOP: begin
				wt_raddr = wt_addr(j_q, nidx);
				ph_raddr = j_q;
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == AW'(WDEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (accept) state_d = ST_FETCH;
			ST_FETCH: begin
				if (!node_ok) begin
					state_d = ST_IDLE;
				end else if (func_q == FUNC_WR_WEIGHT) begin
					state_d = src_ok ? ST_WUPD : ST_IDLE;
				end else if (func_q == FUNC_EVAL) begin
					state_d = ST_ESELF;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WUPD:   state_d = ST_IDLE;
			ST_ESELF:  state_d = (NODES > 1) ? ST_ELOOP : ST_EDRAIN;
			ST_ELOOP:  if (is_last_j) state_d = ST_EDRAIN;
			ST_EDRAIN: if (drain_done) state_d = ST_EDIV;
			ST_EDIV:   if (div_done) state_d = ST_EMUL;
			ST_EMUL:   state_d = ST_ESUM;
			ST_ESUM:   state_d = ST_EOUT;
			ST_EOUT:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupling_gain_q <= '0;
			forcing_gain_q  <= '0;
			freq_ventral_q  <= 32'sd16777216;
			freq_dorsal_q   <= 32'sd16777216;
			daylight_q      <= 16'd32768;
			ventral_count_q <= 8'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COUPLING_GAIN: coupling_gain_q <= signed'(cfg_data);
				REG_FORCING_GAIN:  forcing_gain_q  <= signed'(cfg_data);
				REG_FREQ_VENTRAL:  freq_ventral_q  <= signed'(cfg_data);
				REG_FREQ_DORSAL:   freq_dorsal_q   <= signed'(cfg_data);
				REG_DAYLIGHT:      daylight_q      <= cfg_data[15:0];
				REG_VENTRAL_COUNT: ventral_count_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Control counters and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			j_q         <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			// neighbor walk: j = 0 issued in ESELF, the rest in ELOOP
			if (state_q == ST_ESELF) begin
				j_q <= NW'(1);
			end else if (state_q == ST_ELOOP) begin
				j_q <= j_q + NW'(1);
			end
			rd_v_s1 <= (state_q == ST_ESELF) || (state_q == ST_ELOOP);
			v_s2    <= rd_v_s1;
			if (state_q == ST_EDRAIN && drain_done) begin
				div_cnt_q <= DCW'(SUMW);
			end else if (state_q == ST_EDIV && !div_done) begin
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			if (state_q == ST_EOUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		logic [DEGW:0]   trial;
		logic            ge;
		logic [1:0]      rl3;
		logic            fix3;
		logic signed [31:0] inter;
		logic signed [31:0] fval;
		logic signed [31:0] omega;
		logic signed [63:0] tot;

		// capture input beat
		if (accept) begin
			func_q   <= func;
			node_q   <= node;
			source_q <= source;
			case (weight)
				2'sd0:   wenc_q <= W_ZERO;
				2'sd1:   wenc_q <= W_POS;
				default: wenc_q <= W_NEG;
			endcase
			ffac_q  <= freq_factor;
			phase_q <= phase_turns;
			time_q  <= time_turns;
		end

		// own node data, light-profile argument x (argument is 4x/3)
		if (state_q == ST_ESELF) begin
			self_q <= ph_rdata;
			deg_q  <= dg_rdata;
			freq_q <= fq_rdata;
			sum_q  <= '0;
			dead_q <= (ph_rdata > PH_DAWN) && (ph_rdata < PH_DUSK);
			if (ph_rdata > PH_DUSK) begin
				x3_q <= {1'b0, ph_rdata - PH_DUSK};
			end else begin
				x3_q <= {1'b0, ph_rdata} + PH_SHIFT;
			end
		end

		// 4x/3 = x + x/3: low word by reciprocal, top bit adds 2^32/3 and carry
		m3_q <= 64'(x3_q[31:0]) * 64'(RECIP3);
		rl3  = 2'(x3_q[1:0] + m3_q[34:33]);
		fix3 = x3_q[32] && (rl3 == 2'd2);
		q3_q <= x3_q[31:0] + 32'(m3_q[63:33]) + (x3_q[32] ? THIRD_2_32 : 32'd0)
			+ 32'(fix3);

		// s1: sine of the phase difference
		w_s2   <= wt_rdata;
		sin_s2 <= sine_lookup(ph_rdata - self_q);

		// s2: accumulate weighted sine
		if (v_s2) begin
			if (w_s2 == W_POS) begin
				sum_q <= sum_q + SUMW'(sin_s2);
			end else if (w_s2 == W_NEG) begin
				sum_q <= sum_q - SUMW'(sin_s2);
			end
		end

		// divider: magnitude of sum over in-degree, restoring, one bit a cycle
		if (state_q == ST_EDRAIN && drain_done) begin
			neg_q <= sum_q[SUMW-1];
			quo_q <= sum_q[SUMW-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
			rem_q <= '0;
		end else if (state_q == ST_EDIV && !div_done) begin
			trial = {rem_q[DEGW-1:0], quo_q[SUMW-1]};
			ge    = (trial >= {1'b0, deg_q});
			rem_q <= ge ? (trial - {1'b0, deg_q}) : trial;
			quo_q <= {quo_q[SUMW-2:0], ge};
		end

		// products
		if (state_q == ST_EMUL) begin
			if (deg_q == '0) begin
				inter = '0;
			end else begin
				inter = neg_q ? -signed'(quo_q[31:0]) : signed'(quo_q[31:0]);
			end
			fval  = dead_q ? 32'sd0 : sine_lookup(q3_q);
			omega = ventral ? freq_ventral_q : freq_dorsal_q;
			prod_k_q <= coupling_gain_q * inter;
			prod_w_q <= omega * signed'({1'b0, freq_q});
			prod_f_q <= force_en ? (forcing_gain_q * fval) : 64'sd0;
		end

		// sum of terms with floor shifts, saturate
		if (state_q == ST_ESUM) begin
			tot = (prod_w_q >>> 14) + (prod_k_q >>> 30) + (prod_f_q >>> 30);
			if (tot > SAT_HI) begin
				total_q <= 32'sh7FFF_FFFF;
			end else if (tot < SAT_LO) begin
				total_q <= -32'sh8000_0000;
			end else begin
				total_q <= tot[31:0];
			end
		end

		// output register
		if (state_q == ST_EOUT && out_free) begin
			node_out_q  <= node_q;
			deriv_q     <= total_q;
			light_out_q <= light;
		end
	end

endmodule

`default_nettype wire

// File: rtl/kpd_checker.sv
// Port-level checker for the Kuramoto phase-derivative block, bound to the top.
// Depends only on the top-level ports.
`default_nettype none

module kpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [6:0]  node_out,
	input wire logic [31:0] derivative,
	input wire logic        light_on
);

	// a stalled result beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(node_out) && $stable(derivative) && $stable(light_on))
		else $error("result payload changed while stalled");

	// one beat at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a beat was in flight");

	// a new result only comes out of a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in flight");

endmodule

bind kuramoto_phase_derivative kpd_checker u_kpd_checker (.*);

`default_nettype wire
